@@ src/bc_pkg.sv @@
// shared types, constants and microcode program of the binomial coefficient block
`default_nettype none
package bc_pkg;

  // largest n that is served
  localparam int unsigned MaxN = 63;
  // width of the n and k fields
  localparam int unsigned NW = 6;
  // result width
  localparam int unsigned CoefW = 64;
  // row store depth and address width
  localparam int unsigned MemDepth = MaxN + 1;
  localparam int unsigned AddrW = $clog2(MemDepth);

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t StepIdle  = 3'd0;
  localparam step_t StepClear = 3'd1;
  localparam step_t StepRow   = 3'd2;
  localparam step_t StepRdHi  = 3'd3;
  localparam step_t StepAdd   = 3'd4;
  localparam step_t StepFinRd = 3'd5;
  localparam step_t StepFin   = 3'd6;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_ADD   = 2'd2
  } wr_op_e;

  typedef enum logic [1:0] {
    RD_MIN    = 2'd0,
    RD_COL_M1 = 2'd1,
    RD_COL_M2 = 2'd2,
    RD_K      = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    COL_HOLD = 2'd0,
    COL_INC  = 2'd1,
    COL_MIN  = 2'd2,
    COL_DEC  = 2'd3
  } col_op_e;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_START    = 3'd1,
    C_COL_IS_K = 3'd2,
    C_ROW_DONE = 3'd3,
    C_COL_ONE  = 3'd4,
    C_OUT_FREE = 3'd5
  } cond_e;

  // one control word of the program
  typedef struct packed {
    logic    accept_en;
    wr_op_e  wr_op;
    rd_sel_e rd_sel;
    col_op_e col_op;
    logic    row_inc;
    logic    ld_upper;
    logic    ld_out;
    cond_e   cond;
    step_t   tgt_t;
    step_t   tgt_f;
  } ctrl_word_t;

  // status flags from the datapath
  typedef struct packed {
    logic req_bad;
    logic col_is_k;
    logic row_done;
    logic col_one;
    logic out_free;
    logic accept;
  } dp_status_t;

  // microcode rom
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{accept_en: 1'b0, wr_op: WR_NONE, rd_sel: RD_K, col_op: COL_HOLD,
          row_inc: 1'b0, ld_upper: 1'b0, ld_out: 1'b0, cond: C_ALWAYS,
          tgt_t: StepIdle, tgt_f: StepIdle};
    case (step)
      StepIdle: begin
        w.accept_en = 1'b1;
        w.cond      = C_START;
        w.tgt_t     = StepClear;
        w.tgt_f     = StepIdle;
      end
      StepClear: begin
        w.wr_op  = WR_CLEAR;
        w.col_op = COL_INC;
        w.cond   = C_COL_IS_K;
        w.tgt_t  = StepRow;
        w.tgt_f  = StepClear;
      end
      StepRow: begin
        w.rd_sel  = RD_MIN;
        w.col_op  = COL_MIN;
        w.row_inc = 1'b1;
        w.cond    = C_ROW_DONE;
        w.tgt_t   = StepFinRd;
        w.tgt_f   = StepRdHi;
      end
      StepRdHi: begin
        w.rd_sel   = RD_COL_M1;
        w.ld_upper = 1'b1;
        w.cond     = C_ALWAYS;
        w.tgt_t    = StepAdd;
      end
      StepAdd: begin
        w.wr_op    = WR_ADD;
        w.rd_sel   = RD_COL_M2;
        w.col_op   = COL_DEC;
        w.ld_upper = 1'b1;
        w.cond     = C_COL_ONE;
        w.tgt_t    = StepRow;
        w.tgt_f    = StepAdd;
      end
      StepFinRd: begin
        w.rd_sel = RD_K;
        w.cond   = C_ALWAYS;
        w.tgt_t  = StepFin;
      end
      StepFin: begin
        w.rd_sel = RD_K;
        w.ld_out = 1'b1;
        w.cond   = C_OUT_FREE;
        w.tgt_t  = StepIdle;
        w.tgt_f  = StepFin;
      end
      default: begin
        w.tgt_t = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ src/bc_sequencer.sv @@
// microcode sequencer: step counter, rom lookup and conditional jumps
`default_nettype none
module bc_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bc_pkg::dp_status_t status_i,
  output bc_pkg::ctrl_word_t      ctrl_o
);

  bc_pkg::step_t      upc_q, upc_d;
  bc_pkg::ctrl_word_t word;
  logic               taken;

  // control word of the current step
  assign word   = bc_pkg::ucode(upc_q);
  assign ctrl_o = word;

  // jump condition
  always_comb begin
    case (word.cond)
      bc_pkg::C_ALWAYS:   taken = 1'b1;
      bc_pkg::C_START:    taken = status_i.accept & ~status_i.req_bad;
      bc_pkg::C_COL_IS_K: taken = status_i.col_is_k;
      bc_pkg::C_ROW_DONE: taken = status_i.row_done;
      bc_pkg::C_COL_ONE:  taken = status_i.col_one;
      bc_pkg::C_OUT_FREE: taken = status_i.out_free;
      default:            taken = 1'b1;
    endcase
  end

  assign upc_d = taken ? word.tgt_t : word.tgt_f;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= bc_pkg::StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule
`default_nettype wire

@@ src/bc_datapath.sv @@
// datapath: row store, row and column counters, adder and output register
`default_nettype none
module bc_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bc_pkg::ctrl_word_t         ctrl_i,
  input  wire logic                       accept_i,
  input  wire logic [bc_pkg::NW-1:0]      row_count_i,
  input  wire logic [bc_pkg::NW-1:0]      choose_count_i,
  input  wire logic                       out_stall_i,
  output bc_pkg::dp_status_t              status_o,
  output logic                            out_valid_o,
  output logic [bc_pkg::CoefW-1:0]        coefficient_o,
  output logic                            invalid_o
);

  logic [bc_pkg::CoefW-1:0] mem_q [bc_pkg::MemDepth];
  logic [bc_pkg::CoefW-1:0] rdata_q;
  logic [bc_pkg::CoefW-1:0] upper_q;
  logic [bc_pkg::CoefW-1:0] wdata;
  logic [bc_pkg::NW-1:0]    n_q, k_q, row_q, col_q, col_d;
  logic [bc_pkg::NW-1:0]    row_next, col_min;
  logic [bc_pkg::AddrW-1:0] rd_addr, wr_addr;
  logic                     wr_en;
  logic                     req_bad;
  logic                     out_free;
  logic                     out_valid_q;
  logic [bc_pkg::CoefW-1:0] coef_q;
  logic                     invalid_q;

  // request check
  assign req_bad = (choose_count_i > row_count_i) ||
                   ({1'b0, row_count_i} > (bc_pkg::NW + 1)'(bc_pkg::MaxN));

  assign out_free = ~out_valid_q | ~out_stall_i;

  // first column touched in the next row
  assign row_next = row_q + bc_pkg::NW'(1);
  assign col_min  = (row_next < k_q) ? row_next : k_q;

  // status to the sequencer
  assign status_o.req_bad  = req_bad;
  assign status_o.col_is_k = (col_q == k_q);
  assign status_o.row_done = (row_q == n_q) || (k_q == '0);
  assign status_o.col_one  = (col_q == bc_pkg::NW'(1));
  assign status_o.out_free = out_free;
  assign status_o.accept   = accept_i;

  // column counter next value
  always_comb begin
    case (ctrl_i.col_op)
      bc_pkg::COL_HOLD: col_d = col_q;
      bc_pkg::COL_INC:  col_d = col_q + bc_pkg::NW'(1);
      bc_pkg::COL_MIN:  col_d = col_min;
      bc_pkg::COL_DEC:  col_d = col_q - bc_pkg::NW'(1);
      default:          col_d = col_q;
    endcase
  end

  // request and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      k_q   <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      n_q   <= row_count_i;
      k_q   <= choose_count_i;
      row_q <= '0;
      col_q <= '0;
    end else begin
      col_q <= col_d;
      if (ctrl_i.row_inc && !status_o.row_done) begin
        row_q <= row_next;
      end
    end
  end

  // read address select
  always_comb begin
    case (ctrl_i.rd_sel)
      bc_pkg::RD_MIN:    rd_addr = bc_pkg::AddrW'(col_min);
      bc_pkg::RD_COL_M1: rd_addr = bc_pkg::AddrW'(col_q - bc_pkg::NW'(1));
      bc_pkg::RD_COL_M2: rd_addr = bc_pkg::AddrW'(col_q - bc_pkg::NW'(2));
      bc_pkg::RD_K:      rd_addr = bc_pkg::AddrW'(k_q);
      default:           rd_addr = bc_pkg::AddrW'(k_q);
    endcase
  end

  // write port: seed row zero or add the left neighbor
  assign wr_addr = bc_pkg::AddrW'(col_q);
  assign wr_en   = (ctrl_i.wr_op == bc_pkg::WR_CLEAR) || (ctrl_i.wr_op == bc_pkg::WR_ADD);
  always_comb begin
    case (ctrl_i.wr_op)
      bc_pkg::WR_CLEAR: wdata = (col_q == '0) ? bc_pkg::CoefW'(1) : '0;
      bc_pkg::WR_ADD:   wdata = upper_q + rdata_q;
      default:          wdata = '0;
    endcase
  end

  // row store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // entry held for the next add
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_upper) begin
      upper_q <= rdata_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((accept_i && req_bad) || (ctrl_i.ld_out && out_free)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && req_bad) begin
      coef_q    <= '0;
      invalid_q <= 1'b1;
    end else if (ctrl_i.ld_out && out_free) begin
      coef_q    <= rdata_q;
      invalid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign invalid_o     = invalid_q;

endmodule
`default_nettype wire

@@ src/binomial_coefficient.sv @@
// binomial coefficient C(n,k) by in-place pascal rows under a microcoded sequencer
// steps: seed the row store, update each row r=1..n in place (none when k is 0),
//   then read out the result
// one request at a time, one row entry added per cycle; next word taken at the idle step
// rejected request (k > n): word returned the next cycle, one per cycle unless out_stall_i
// reset (rst_ni low, asynchronous) empties the output register and returns to idle
`default_nettype none
module binomial_coefficient (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [bc_pkg::NW-1:0]      row_count_i,
  input  wire logic [bc_pkg::NW-1:0]      choose_count_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [bc_pkg::CoefW-1:0]        coefficient_o,
  output logic                            invalid_o
);

  bc_pkg::ctrl_word_t ctrl;
  bc_pkg::dp_status_t status;
  logic               accept;

  // input handshake: take a word only at the idle step with room for a result
  assign in_stall_o = ~(ctrl.accept_en & status.out_free);
  assign accept     = in_valid_i & ~in_stall_o;

  // control
  bc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // datapath
  bc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .accept_i       (accept),
    .row_count_i    (row_count_i),
    .choose_count_i (choose_count_i),
    .out_stall_i    (out_stall_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .coefficient_o  (coefficient_o),
    .invalid_o      (invalid_o)
  );

  // a rejected word carries a zero coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (coefficient_o == '0))
    else $error("rejected word with nonzero coefficient");

  // a rejected request shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status.req_bad) |=> (out_valid_o && invalid_o))
    else $error("rejected request not returned");

  // a started computation blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status.req_bad) |=> in_stall_o)
    else $error("input taken while computing");

endmodule
`default_nettype wire
